@@ src/gasp_pkg.sv @@
// Shared field widths, codes and reset values for the grid smoothing block.
// Used by the RAM wrapper users, the neighbour-count lanes, the top level
// and the port checker.
package gasp_pkg;

  localparam int OP_W       = 2;
  localparam int ROW_W      = 6;
  localparam int COL_W      = 7;
  localparam int CNT_W      = 4;
  localparam int THR_W      = 4;
  localparam int NROWS_W    = 7;
  localparam int NCOLS_W    = 8;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 8;

  // Operation codes carried in the op field.
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_PASS  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROWS      = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_COLS      = 2'd2;

  localparam logic [THR_W-1:0]   THR_RESET  = 4'd4;
  localparam logic [NROWS_W-1:0] ROWS_RESET = 7'd50;
  localparam logic [NCOLS_W-1:0] COLS_RESET = 8'd80;

  // Maximum live-neighbour count of a cell.
  localparam logic [CNT_W-1:0] CNT_MAX = 4'd8;

endpackage

@@ src/gasp_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module gasp_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/gasp_nbr.sv @@
// Neighbour-count lanes: one lane per column counts live cells around it in a
// three-row window and forms the smoothed row. Depends on gasp_pkg.
module gasp_nbr #(
  parameter int MAX_COLS = 128,
  parameter int CCW      = 8
) (
  input  logic [MAX_COLS-1:0]           up_row,
  input  logic [MAX_COLS-1:0]           mid_row,
  input  logic [MAX_COLS-1:0]           dn_row,
  input  logic [CCW-1:0]                ncols,
  input  logic [gasp_pkg::THR_W-1:0]    thresh,
  input  logic [$clog2(MAX_COLS)-1:0]   sel_col,
  output logic [MAX_COLS-1:0]           new_row,
  output logic [gasp_pkg::CNT_W-1:0]    sel_count
);

  import gasp_pkg::*;

  logic [MAX_COLS-1:0] mask;
  logic [MAX_COLS-1:0] u_m;
  logic [MAX_COLS-1:0] m_m;
  logic [MAX_COLS-1:0] d_m;
  logic [CNT_W-1:0]    cnt [MAX_COLS];

  // Cells beyond the columns in use count as dead.
  assign u_m = up_row & mask;
  assign m_m = mid_row & mask;
  assign d_m = dn_row & mask;

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_lane
    localparam logic [CCW-1:0] CIDX = CCW'(c);
    logic ul, ur, ml, mr, dl, dr;

    assign mask[c] = (CIDX < ncols);

    if (c > 0) begin : g_left
      assign ul = u_m[c-1];
      assign ml = m_m[c-1];
      assign dl = d_m[c-1];
    end else begin : g_left_edge
      assign ul = 1'b0;
      assign ml = 1'b0;
      assign dl = 1'b0;
    end

    if (c < MAX_COLS - 1) begin : g_right
      assign ur = u_m[c+1];
      assign mr = m_m[c+1];
      assign dr = d_m[c+1];
    end else begin : g_right_edge
      assign ur = 1'b0;
      assign mr = 1'b0;
      assign dr = 1'b0;
    end

    assign cnt[c] = CNT_W'(ul) + CNT_W'(u_m[c]) + CNT_W'(ur) + CNT_W'(ml) +
                    CNT_W'(mr) + CNT_W'(dl) + CNT_W'(d_m[c]) + CNT_W'(dr);

    // Columns outside the grid in use keep their old value.
    assign new_row[c] = mask[c] ? (cnt[c] > thresh) : mid_row[c];
  end

  assign sel_count = cnt[sel_col];

endmodule

@@ src/grid_automaton_smoothing_pass.sv @@
// Grid smoothing block: a binary grid held one row per RAM word. A bad address, an
// empty-grid pass or an unused op goes straight to the result; a write reads the row
// word and writes it back, a read fetches the rows around the cell, and a pass
// sweeps the rows in use (at most MAX_ROWS), one row word per cycle, through the RAM
// read port. One item at a time; the next is taken once the result is registered.
// Reset (rst_n, synchronous) clears control and configuration, not the grid.
module grid_automaton_smoothing_pass #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 128
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: op[1:0], row[7:2], col[14:8], cell_in[15]
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [gasp_pkg::IN_TDATA_W-1:0]    in_tdata,
  // out_tdata: cell_out[0], live_neighbours[4:1], bad_address[5], zero[7:6]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [gasp_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_we,
  input  logic [gasp_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [gasp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  import gasp_pkg::*;

  localparam int RAW  = $clog2(MAX_ROWS);
  localparam int CAW  = $clog2(MAX_COLS);
  localparam int RCW0 = $clog2(MAX_ROWS + 1);
  localparam int CCW0 = $clog2(MAX_COLS + 1);
  localparam int RCW  = (RCW0 > NROWS_W) ? RCW0 : NROWS_W;
  localparam int CCW  = (CCW0 > NCOLS_W) ? CCW0 : NCOLS_W;

  typedef enum logic [2:0] {
    S_IDLE, S_WR, S_PS0, S_PS, S_RDA, S_RDB, S_RDC, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  logic [THR_W-1:0]   thr_r;
  logic [NROWS_W-1:0] rows_r;
  logic [NCOLS_W-1:0] cols_r;

  logic [RCW-1:0]      row_r, row_nxt;
  logic [CAW-1:0]      col_r, col_nxt;
  logic                cell_r, cell_nxt;
  logic [RCW-1:0]      idx_r, idx_nxt;
  logic [MAX_COLS-1:0] up_r, up_nxt;
  logic [MAX_COLS-1:0] mid_r, mid_nxt;
  logic                res_cell_r, res_cell_nxt;
  logic [CNT_W-1:0]    res_cnt_r, res_cnt_nxt;
  logic                res_bad_r, res_bad_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_cell_r, out_cell_nxt;
  logic [CNT_W-1:0]    out_cnt_r, out_cnt_nxt;
  logic                out_bad_r, out_bad_nxt;

  // Input fields.
  logic [OP_W-1:0]  in_op;
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] in_col;
  logic             in_cell;
  logic [RCW-1:0]   in_row_ext, in_row_m1;
  logic [CCW-1:0]   in_col_ext;

  logic [RCW-1:0] nr;
  logic [CCW-1:0] nc;
  logic           in_bad;
  logic [RCW-1:0] row_p1, idx_p1, idx_p2;
  logic           dn_ok;
  logic [MAX_COLS-1:0] dn_w;
  logic [MAX_COLS-1:0] wr_word;
  logic [MAX_COLS-1:0] new_row;
  logic [CNT_W-1:0]    sel_count;

  logic                ram_we, ram_re;
  logic [RAW-1:0]      ram_waddr, ram_raddr;
  logic [MAX_COLS-1:0] ram_wdata, ram_rdata;

  assign in_op   = in_tdata[1:0];
  assign in_row  = in_tdata[7:2];
  assign in_col  = in_tdata[14:8];
  assign in_cell = in_tdata[15];

  assign in_row_ext = RCW'(in_row);
  assign in_col_ext = CCW'(in_col);
  assign in_row_m1  = in_row_ext - RCW'(1);

  // Register values above the storage size act as the storage size.
  assign nr = (RCW'(rows_r) > RCW'(MAX_ROWS)) ? RCW'(MAX_ROWS) : RCW'(rows_r);
  assign nc = (CCW'(cols_r) > CCW'(MAX_COLS)) ? CCW'(MAX_COLS) : CCW'(cols_r);

  assign in_bad = (in_row_ext >= nr) || (in_col_ext >= nc);

  assign row_p1 = row_r + RCW'(1);
  assign idx_p1 = idx_r + RCW'(1);
  assign idx_p2 = idx_r + RCW'(2);

  // The row below the window is dead when it lies past the rows in use.
  assign dn_ok = (state_r == S_PS) ? (idx_p1 < nr) : (row_p1 < nr);
  assign dn_w  = dn_ok ? ram_rdata : '0;

  always_comb begin
    wr_word        = ram_rdata;
    wr_word[col_r] = cell_r;
  end

  gasp_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gasp_nbr #(
    .MAX_COLS (MAX_COLS),
    .CCW      (CCW)
  ) u_nbr (
    .up_row    (up_r),
    .mid_row   (mid_r),
    .dn_row    (dn_w),
    .ncols     (nc),
    .thresh    (thr_r),
    .sel_col   (col_r),
    .new_row   (new_row),
    .sel_count (sel_count)
  );

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    cell_nxt      = cell_r;
    idx_nxt       = idx_r;
    up_nxt        = up_r;
    mid_nxt       = mid_r;
    res_cell_nxt  = res_cell_r;
    res_cnt_nxt   = res_cnt_r;
    res_bad_nxt   = res_bad_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_cell_nxt  = out_cell_r;
    out_cnt_nxt   = out_cnt_r;
    out_bad_nxt   = out_bad_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          row_nxt      = in_row_ext;
          col_nxt      = in_col_ext[CAW-1:0];
          cell_nxt     = in_cell;
          res_cell_nxt = 1'b0;
          res_cnt_nxt  = '0;
          res_bad_nxt  = 1'b0;
          state_nxt    = S_DONE;
          unique case (in_op)
            OP_WRITE: begin
              if (in_bad) begin
                res_bad_nxt = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = in_row_ext[RAW-1:0];
                state_nxt = S_WR;
              end
            end
            OP_PASS: begin
              if (nr != '0 && nc != '0) begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                state_nxt = S_PS0;
              end
            end
            OP_READ: begin
              if (in_bad) begin
                res_bad_nxt = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = in_row_m1[RAW-1:0];
                state_nxt = S_RDA;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_WR: begin
        ram_we    = 1'b1;
        ram_waddr = row_r[RAW-1:0];
        ram_wdata = wr_word;
        state_nxt = S_DONE;
      end
      S_PS0: begin
        up_nxt    = '0;
        mid_nxt   = ram_rdata;
        idx_nxt   = '0;
        ram_re    = 1'b1;
        ram_raddr = RAW'(1);
        state_nxt = S_PS;
      end
      S_PS: begin
        // Write row idx while the row two below it is fetched; the window
        // still holds the old rows, so no snapshot copy is needed.
        ram_we    = 1'b1;
        ram_waddr = idx_r[RAW-1:0];
        ram_wdata = new_row;
        ram_re    = 1'b1;
        ram_raddr = idx_p2[RAW-1:0];
        up_nxt    = mid_r;
        mid_nxt   = dn_w;
        if (idx_p1 == nr) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_p1;
        end
      end
      S_RDA: begin
        up_nxt    = (row_r != '0) ? ram_rdata : '0;
        ram_re    = 1'b1;
        ram_raddr = row_r[RAW-1:0];
        state_nxt = S_RDB;
      end
      S_RDB: begin
        mid_nxt   = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = row_p1[RAW-1:0];
        state_nxt = S_RDC;
      end
      S_RDC: begin
        res_cell_nxt = mid_r[col_r];
        res_cnt_nxt  = sel_count;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_cell_nxt  = res_cell_r;
          out_cnt_nxt   = res_cnt_r;
          out_bad_nxt   = res_bad_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      thr_r       <= THR_RESET;
      rows_r      <= ROWS_RESET;
      cols_r      <= COLS_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_THRESHOLD: thr_r  <= cfg_wdata[THR_W-1:0];
          CFG_ROWS:      rows_r <= cfg_wdata[NROWS_W-1:0];
          CFG_COLS:      cols_r <= cfg_wdata[NCOLS_W-1:0];
          default: begin
          end
        endcase
      end
    end
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    cell_r     <= cell_nxt;
    idx_r      <= idx_nxt;
    up_r       <= up_nxt;
    mid_r      <= mid_nxt;
    res_cell_r <= res_cell_nxt;
    res_cnt_r  <= res_cnt_nxt;
    res_bad_r  <= res_bad_nxt;
    out_cell_r <= out_cell_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_bad_r, out_cnt_r, out_cell_r};

endmodule

@@ src/gasp_chk.sv @@
// Port-level checker for the grid smoothing block, bound to the top level.
// Depends on gasp_pkg.
module gasp_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [gasp_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  import gasp_pkg::*;

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // The block works on one item at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a transfer");

  // A flagged address carries neither a cell value nor a count.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[5] |-> out_tdata[4:0] == 5'd0)
    else $error("bad address with nonzero payload");

  // The count never exceeds eight and the padding stays zero.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[4:1] <= CNT_MAX && out_tdata[7:6] == 2'b00)
    else $error("neighbour count out of range");

endmodule

bind grid_automaton_smoothing_pass gasp_chk u_gasp_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ tb/sv/grid_smoothing_monitor.sv @@
// Monitor for the grid smoothing block: keeps its own copy of the grid and
// the three registers, predicts each result and compares it with the block.
// Depends on gasp_pkg for field widths, operation codes and register indexes.
`timescale 1ns / 1ps

module grid_smoothing_monitor (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: op[1:0], row[7:2], col[14:8], cell_in[15]
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [gasp_pkg::IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: cell_out[0], live_neighbours[4:1], bad_address[5], zero[7:6]
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [gasp_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_we,
  input  logic [gasp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [gasp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             run_done,
  output int                               failures
);
  import gasp_pkg::*;

  localparam int GRID_ROWS = 64;
  localparam int GRID_COLS = 128;
  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic             cell_val;
    logic [CNT_W-1:0] neighbours;
    logic             bad;
  } cell_report_t;

  bit [GRID_COLS-1:0] grid_now  [GRID_ROWS];
  bit [GRID_COLS-1:0] grid_prev [GRID_ROWS];
  logic [THR_W-1:0]   threshold;
  logic [NROWS_W-1:0] rows_cfg;
  logic [NCOLS_W-1:0] cols_cfg;
  cell_report_t       awaited_reports [$];
  bit                 drained = 1'b0;

  task automatic note_mismatch(input string what);
    failures++;
    if (failures <= PRINT_CAP) $display("%0t mismatch: %s", $time, what);
  endtask

  // Cells outside the nr x nc grid in use count as dead.
  function automatic int live_around(input bit from_prev, input int r, input int c,
                                     input int nr, input int nc);
    int n;
    int rr;
    int cc;
    n = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        rr = r + dr;
        cc = c + dc;
        if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 && rr < nr && cc < nc)
          n += int'(from_prev ? grid_prev[rr][cc] : grid_now[rr][cc]);
      end
    end
    return n;
  endfunction

  function automatic cell_report_t apply_grid_op(input logic [IN_TDATA_W-1:0] word);
    logic [OP_W-1:0] op;
    int              row;
    int              col;
    int              nr;
    int              nc;
    bit              bad;
    cell_report_t    res;
    op  = word[1:0];
    row = int'(word[7:2]);
    col = int'(word[14:8]);
    nr  = (int'(rows_cfg) > GRID_ROWS) ? GRID_ROWS : int'(rows_cfg);
    nc  = (int'(cols_cfg) > GRID_COLS) ? GRID_COLS : int'(cols_cfg);
    bad = (row >= nr) || (col >= nc);
    res = '0;
    case (op)
      OP_WRITE: begin
        if (bad) res.bad = 1'b1;
        else grid_now[row][col] = word[15];
      end
      OP_PASS: begin
        for (int r = 0; r < nr; r++) grid_prev[r] = grid_now[r];
        for (int r = 0; r < nr; r++)
          for (int c = 0; c < nc; c++)
            grid_now[r][c] = (live_around(1'b1, r, c, nr, nc) > int'(threshold));
      end
      OP_READ: begin
        if (bad) begin
          res.bad = 1'b1;
        end else begin
          res.cell_val   = grid_now[row][col];
          res.neighbours = CNT_W'(live_around(1'b0, row, col, nr, nc));
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic compare_report(input logic [OUT_TDATA_W-1:0] word);
    cell_report_t want;
    if (awaited_reports.size() == 0) begin
      note_mismatch($sformatf("result %h arrived with nothing pending", word));
      return;
    end
    want = awaited_reports.pop_front();
    if (word[0] !== want.cell_val)
      note_mismatch($sformatf("cell_out %b, expected %b", word[0], want.cell_val));
    if (word[4:1] !== want.neighbours)
      note_mismatch($sformatf("live_neighbours %0d, expected %0d", word[4:1],
                              want.neighbours));
    if (word[5] !== want.bad)
      note_mismatch($sformatf("bad_address %b, expected %b", word[5], want.bad));
    if (word[7:6] !== 2'b00)
      note_mismatch($sformatf("padding bits %b are not zero", word[7:6]));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      threshold = THR_RESET;
      rows_cfg  = ROWS_RESET;
      cols_cfg  = COLS_RESET;
      awaited_reports.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_THRESHOLD: threshold = cfg_wdata[THR_W-1:0];
          CFG_ROWS:      rows_cfg  = cfg_wdata[NROWS_W-1:0];
          CFG_COLS:      cols_cfg  = cfg_wdata[NCOLS_W-1:0];
          default: ;
        endcase
      end
      // The result side goes first so that a result can never match the
      // item taken at the same edge.
      if (out_tvalid && out_tready) compare_report(out_tdata);
      if (in_tvalid && in_tready) awaited_reports.push_back(apply_grid_op(in_tdata));
      if (run_done && !drained) begin
        drained = 1'b1;
        while (awaited_reports.size() > 0) begin
          void'(awaited_reports.pop_front());
          note_mismatch("expected result never arrived");
        end
      end
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the grid smoothing testbench: clock, reset, stimulus and result-side
// flow control, with the verdict. Depends on gasp_pkg, the block itself and
// grid_smoothing_monitor, which does all prediction and checking.
`timescale 1ns / 1ps

module testbench;
  import gasp_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int GRID_ROWS       = 64;
  localparam int GRID_COLS       = 128;
  localparam int FILL_ROWS       = 6;
  localparam int FILL_COLS       = 12;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_ITEMS    = 300;
  localparam int PHASES          = 10;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tready = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;
  logic                   run_done   = 1'b0;
  wire                    in_tready;
  wire                    out_tvalid;
  wire [OUT_TDATA_W-1:0]  out_tdata;
  int                     failures;

  int sent          = 0;
  int returned      = 0;
  int idle_cycles   = 0;
  int calm_items    = 0;
  int rows_now      = int'(ROWS_RESET);
  int cols_now      = int'(COLS_RESET);
  bit hold_off_req  = 1'b0;
  bit hold_off_seen = 1'b0;

  // Every grid in use stays inside the loaded cells: the small block at the
  // top left, the first column or the first row.
  int phase_thr  [6] = '{4, 0, 8, 15, 3, 5};
  int phase_rows [6] = '{6, 3, 127, 1, 1, 64};
  int phase_cols [6] = '{12, 3, 1, 255, 12, 1};

  grid_automaton_smoothing_pass dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  grid_smoothing_monitor grid_watch (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .run_done   (run_done),
    .failures   (failures)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (in_tvalid && in_tready) sent++;
    if (out_tvalid && out_tready) returned++;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Mostly short gaps, now and then a long one, and runs of items without gaps.
  function automatic int next_gap();
    int pick;
    if (calm_items > 0) begin
      calm_items--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      calm_items = $urandom_range(10, 40);
      return 0;
    end
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Called and returns at a falling edge, after the transfer has happened.
  task automatic offer(input logic [OP_W-1:0] op, input int row, input int col,
                       input logic cell_bit);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {cell_bit, col[6:0], row[5:0], op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (returned != sent) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_grid(input int thr, input int rows, input int cols);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_THRESHOLD;
    cfg_wdata <= CFG_DATA_W'(thr);
    @(negedge clk);
    cfg_addr  <= CFG_ROWS;
    cfg_wdata <= CFG_DATA_W'(rows);
    @(negedge clk);
    cfg_addr  <= CFG_COLS;
    cfg_wdata <= CFG_DATA_W'(cols);
    @(negedge clk);
    cfg_we    <= 1'b0;
    rows_now = rows;
    cols_now = cols;
    @(negedge clk);
  endtask

  task automatic random_item();
    int pick;
    int nr;
    int nc;
    int row;
    int col;
    logic [OP_W-1:0] op;
    nr = (rows_now > GRID_ROWS) ? GRID_ROWS : rows_now;
    nc = (cols_now > GRID_COLS) ? GRID_COLS : cols_now;
    pick = $urandom_range(0, 99);
    if (pick < 38) op = OP_WRITE;
    else if (pick < 50) op = OP_PASS;
    else if (pick < 95) op = OP_READ;
    else op = OP_SPARE;
    // Most addresses land inside the grid in use; the rest may be bad.
    if (nr > 0 && $urandom_range(0, 9) < 8) row = $urandom_range(0, nr - 1);
    else row = $urandom_range(0, GRID_ROWS - 1);
    if (nc > 0 && $urandom_range(0, 9) < 8) col = $urandom_range(0, nc - 1);
    else col = $urandom_range(0, GRID_COLS - 1);
    offer(op, row, col, 1'($urandom_range(0, 1)));
  endtask

  // Result-side flow control, with one long hold-off on request.
  initial begin
    int span;
    int pick;
    @(negedge clk);
    forever begin
      if (hold_off_req && !hold_off_seen) begin
        hold_off_seen = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          out_tready <= 1'b1;
          span = $urandom_range(1, 25);
        end else if (pick < 95) begin
          out_tready <= 1'b0;
          span = $urandom_range(1, 3);
        end else begin
          out_tready <= 1'b0;
          span = $urandom_range(15, 60);
        end
        repeat (span) @(negedge clk);
      end
    end
  end

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Load the top-left block, the first column and the first row; no grid
    // in use ever reaches a cell outside them.
    set_grid(int'(THR_RESET), GRID_ROWS, GRID_COLS);
    // The block holds one item at a time, so a long result-side hold-off
    // soon stalls the input while items are still being offered.
    hold_off_req = 1'b1;
    for (int r = 0; r < FILL_ROWS; r++)
      for (int c = 0; c < FILL_COLS; c++)
        offer(OP_WRITE, r, c, $urandom_range(0, 99) < 45);
    for (int r = FILL_ROWS; r < GRID_ROWS; r++)
      offer(OP_WRITE, r, 0, $urandom_range(0, 99) < 45);
    for (int c = FILL_COLS; c < GRID_COLS; c++)
      offer(OP_WRITE, 0, c, $urandom_range(0, 99) < 45);

    // Corners, edge writes, bad addresses, the spare op and a first pass.
    set_grid(int'(THR_RESET), FILL_ROWS, FILL_COLS);
    offer(OP_READ, 0, 0, 1'b0);
    offer(OP_READ, FILL_ROWS - 1, FILL_COLS - 1, 1'b1);
    offer(OP_READ, 0, FILL_COLS - 1, 1'b0);
    offer(OP_READ, FILL_ROWS - 1, 0, 1'b0);
    offer(OP_WRITE, 0, 0, 1'b1);
    offer(OP_WRITE, FILL_ROWS - 1, FILL_COLS - 1, 1'b1);
    offer(OP_READ, 0, 0, 1'b0);
    offer(OP_READ, FILL_ROWS, 0, 1'b0);
    offer(OP_WRITE, 0, FILL_COLS, 1'b1);
    offer(OP_SPARE, FILL_ROWS - 1, FILL_COLS - 1, 1'b1);
    offer(OP_PASS, 0, 0, 1'b0);
    offer(OP_READ, 1, 1, 1'b0);
    offer(OP_READ, FILL_ROWS - 2, FILL_COLS - 2, 1'b0);
    // A threshold of eight clears the whole grid in use.
    set_grid(8, FILL_ROWS, FILL_COLS);
    offer(OP_PASS, 0, 0, 1'b0);
    offer(OP_READ, 3, 3, 1'b0);
    offer(OP_WRITE, 3, 3, 1'b1);
    // Two by two grid with threshold zero, plus writes and reads off its edge.
    set_grid(0, 2, 2);
    offer(OP_WRITE, 0, 0, 1'b1);
    offer(OP_PASS, 0, 0, 1'b0);
    offer(OP_READ, 1, 1, 1'b0);
    offer(OP_READ, 2, 0, 1'b0);
    offer(OP_WRITE, 0, 2, 1'b1);
    // Empty grids: every address is bad and a pass leaves the cells alone.
    set_grid(4, 0, GRID_COLS);
    offer(OP_READ, 0, 0, 1'b0);
    offer(OP_PASS, 0, 0, 1'b0);
    offer(OP_WRITE, 0, 0, 1'b1);
    set_grid(4, GRID_ROWS, 0);
    offer(OP_READ, 5, 0, 1'b0);
    // Register values beyond the array act as the full array.
    set_grid(2, 127, 1);
    offer(OP_READ, GRID_ROWS - 1, 0, 1'b0);
    offer(OP_PASS, 0, 0, 1'b0);
    offer(OP_READ, GRID_ROWS - 2, 0, 1'b0);
    offer(OP_READ, 10, 1, 1'b0);
    set_grid(0, 1, 255);
    offer(OP_READ, 0, GRID_COLS - 1, 1'b0);
    offer(OP_PASS, 0, 0, 1'b0);
    offer(OP_READ, 0, 64, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      if (p < 6) begin
        set_grid(phase_thr[p], phase_rows[p], phase_cols[p]);
      end else begin
        set_grid(($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8),
                 $urandom_range(1, FILL_ROWS), $urandom_range(1, FILL_COLS));
      end
      for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) random_item();
    end

    wait_idle();
    repeat (10) @(negedge clk);
    run_done <= 1'b1;
    repeat (2) @(negedge clk);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
